/* src/segment_box_mesh_builder_unit_assert.svh */
// Assertion macros for the segment box mesh builder
`ifndef SEGMENT_BOX_MESH_BUILDER_UNIT_ASSERT_SVH
`define SEGMENT_BOX_MESH_BUILDER_UNIT_ASSERT_SVH

// check a property each clock, quiet during reset
`define SBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check an implication to the next cycle
`define SBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/sbm_pkg.sv */
`default_nettype none
package sbm_pkg;

    localparam int unsigned NUM_VERTS = 8;
    localparam int unsigned NUM_RESULTS = 20;
    localparam int unsigned STEP_W = 5;
    localparam logic [31:0] VERT_STRIDE = 32'd8;
    localparam logic signed [31:0] MINUS_ONE = -32'sd1;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI = 1'b1;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_NORM_START,
        OP_AXIS,
        OP_UP_MUL,
        OP_UP_SUM,
        OP_VERT_MUL,
        OP_VERT_ADD
    } sbm_op_t;

    typedef struct packed {
        sbm_op_t op;
        logic [2:0] vsel;
    } sbm_cmd_t;

    typedef struct packed {
        logic norm_busy;
    } sbm_stat_t;

    // one result record
    typedef struct packed {
        logic kind;
        logic [31:0] vertex_index;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic [31:0] tri_a;
        logic [31:0] tri_b;
        logic [31:0] tri_c;
        logic last;
    } sbm_rec_t;

    // triangle corner offsets from base, per triangle
    function automatic logic [8:0] tri_offsets(input logic [3:0] t);
        logic [8:0] r;
        begin
            case (t)
                4'd0: r = {3'd0, 3'd1, 3'd2};
                4'd1: r = {3'd2, 3'd3, 3'd0};
                4'd2: r = {3'd1, 3'd0, 3'd4};
                4'd3: r = {3'd4, 3'd5, 3'd1};
                4'd4: r = {3'd2, 3'd1, 3'd5};
                4'd5: r = {3'd5, 3'd6, 3'd2};
                4'd6: r = {3'd3, 3'd2, 3'd6};
                4'd7: r = {3'd6, 3'd7, 3'd3};
                4'd8: r = {3'd0, 3'd3, 3'd7};
                4'd9: r = {3'd7, 3'd4, 3'd0};
                4'd10: r = {3'd7, 3'd6, 3'd5};
                4'd11: r = {3'd5, 3'd4, 3'd7};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // round v / 2^30 to nearest, halves away from zero
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        begin
            mag = v[63] ? (64'd0 - v) : v;
            r = (mag + 64'h2000_0000) >> 30;
            return v[63] ? $signed(64'd0 - r) : $signed(r);
        end
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        begin
            if (v > 64'sd2147483647)
                r = 32'h7fff_ffff;
            else if (v < -64'sd2147483648)
                r = 32'h8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* src/segment_box_mesh_builder_unit.sv */
`default_nettype none
// Segment box mesh builder.
// Input channel (valid/ready): one segment request with endpoints and radii.
// Output channel (valid/ready): 8 vertex records then 12 triangle records,
// last set on the final triangle.
// One request at a time: ready is high only when the block is idle.
// Each request runs two normalizations on one shared iterative unit (up to 29
// prescale steps, 3 squares, 32 root steps, 3 x 62 divide steps each). The
// first vertex is offered once both normalizations and the up vector are done
// (a zero-length segment skips the squares, root and divide steps). Each later
// vertex passes through the multiply and add states before it is offered, and
// the triangles follow one per cycle while out_ready is high. Throughput is set
// by the normalizer. Reset clears the vertex counter and the controller;
// first_block clears the counter before its request. A stall on the output
// holds the current record unchanged until taken.
module segment_box_mesh_builder_unit
    import sbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic first_block,
    input  wire logic signed [31:0] from_x,
    input  wire logic signed [31:0] from_y,
    input  wire logic signed [31:0] from_z,
    input  wire logic signed [31:0] to_x,
    input  wire logic signed [31:0] to_y,
    input  wire logic signed [31:0] to_z,
    input  wire logic [30:0] from_radius,
    input  wire logic [30:0] to_radius,
    output logic out_valid,
    input  wire logic out_ready,
    output logic kind,
    output logic [31:0] vertex_index,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic signed [31:0] vertex_z,
    output logic [31:0] tri_a,
    output logic [31:0] tri_b,
    output logic [31:0] tri_c,
    output logic last
);

    sbm_cmd_t cmd;
    sbm_stat_t stat;
    sbm_rec_t rec;
    logic [4:0] step;
    logic in_fire;
    logic axis_phase;

    assign in_fire = in_valid && in_ready;

    sbm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_ready(out_ready),
        .stat(stat), .cmd(cmd), .in_ready(in_ready), .out_valid(out_valid),
        .step(step), .out_load(axis_phase)
    );

    sbm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .first_block(first_block),
        .from_x(from_x), .from_y(from_y), .from_z(from_z),
        .to_x(to_x), .to_y(to_y), .to_z(to_z),
        .from_radius(from_radius), .to_radius(to_radius),
        .step(step), .stat(stat), .rec(rec)
    );

    assign kind = rec.kind;
    assign vertex_index = rec.vertex_index;
    assign vertex_x = rec.vertex_x;
    assign vertex_y = rec.vertex_y;
    assign vertex_z = rec.vertex_z;
    assign tri_a = rec.tri_a;
    assign tri_b = rec.tri_b;
    assign tri_c = rec.tri_c;
    assign last = rec.last && !axis_phase;

endmodule
`default_nettype wire

/* src/sbm_norm.sv */
`default_nettype none
// Multicycle vector normalizer: prescale one bit a cycle, squares one per
// cycle, bit-serial square root, then a restoring divide per component.
module sbm_norm
    import sbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic signed [33:0] vin_x,
    input  wire logic signed [33:0] vin_y,
    input  wire logic signed [33:0] vin_z,
    output logic busy,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DSET, N_DIV
    } nstate_t;

    nstate_t state_reg;
    logic [33:0] mag_reg [3];
    logic [2:0] neg_reg;
    logic [63:0] sum_reg;
    logic [63:0] rem_reg;
    logic [31:0] len_reg;
    logic [5:0] cnt_reg;
    logic [1:0] comp_reg;
    logic [61:0] num_reg;
    logic [31:0] q_reg;
    logic [32:0] dr_reg;
    logic [31:0] res_reg [3];

    logic [33:0] m_max;
    logic [33:0] ax, ay, az;
    logic [63:0] sq;
    logic [63:0] trial;
    logic [33:0] dr_sh;

    assign ax = vin_x[33] ? 34'(-vin_x) : vin_x;
    assign ay = vin_y[33] ? 34'(-vin_y) : vin_y;
    assign az = vin_z[33] ? 34'(-vin_z) : vin_z;

    always_comb
    begin
        m_max = mag_reg[0];
        if (mag_reg[1] > m_max)
            m_max = mag_reg[1];
        if (mag_reg[2] > m_max)
            m_max = mag_reg[2];
    end

    assign sq = 64'(mag_reg[comp_reg[1:0] == 2'd3 ? 2'd0 : comp_reg])
              * 64'(mag_reg[comp_reg[1:0] == 2'd3 ? 2'd0 : comp_reg]);
    // sqrt step: trial = (root << 2)+1 style on shifted remainder
    assign trial = {30'd0, len_reg, 2'b01};
    assign dr_sh = {dr_reg, num_reg[61]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg <= '0;
            comp_reg <= '0;
        end
        else
        begin
            case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        mag_reg[0] <= ax;
                        mag_reg[1] <= ay;
                        mag_reg[2] <= az;
                        neg_reg <= {vin_z[33], vin_y[33], vin_x[33]};
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    if (m_max == '0)
                    begin
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        res_reg[2] <= '0;
                        state_reg <= N_IDLE;
                    end
                    else if (m_max >= 34'h4000_0000)
                    begin
                        mag_reg[0] <= mag_reg[0] >> 1;
                        mag_reg[1] <= mag_reg[1] >> 1;
                        mag_reg[2] <= mag_reg[2] >> 1;
                    end
                    else if (m_max < 34'h2000_0000)
                    begin
                        mag_reg[0] <= mag_reg[0] << 1;
                        mag_reg[1] <= mag_reg[1] << 1;
                        mag_reg[2] <= mag_reg[2] << 1;
                    end
                    else
                    begin
                        sum_reg <= '0;
                        comp_reg <= 2'd0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    sum_reg <= sum_reg + sq;
                    if (comp_reg == 2'd2)
                    begin
                        state_reg <= N_SQRT;
                        cnt_reg <= 6'd32;
                        len_reg <= '0;
                        rem_reg <= '0;
                    end
                    else
                        comp_reg <= comp_reg + 2'd1;
                end
                N_SQRT:
                begin
                    // two radicand bits per step
                    if ({rem_reg[61:0], sum_reg[63:62]} >= trial)
                    begin
                        rem_reg <= {rem_reg[61:0], sum_reg[63:62]} - trial;
                        len_reg <= {len_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[61:0], sum_reg[63:62]};
                        len_reg <= {len_reg[30:0], 1'b0};
                    end
                    sum_reg <= {sum_reg[61:0], 2'b00};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                        state_reg <= N_DSET;
                end
                N_DSET:
                begin
                    // root is final here
                    state_reg <= N_DIV;
                    comp_reg <= 2'd0;
                    cnt_reg <= 6'd62;
                    dr_reg <= '0;
                    q_reg <= '0;
                    num_reg <= {mag_reg[0][29:0], 30'd0} + {30'd0, len_reg >> 1};
                end
                N_DIV:
                begin
                    if (dr_sh >= {2'b0, len_reg})
                    begin
                        dr_reg <= 33'(dr_sh - {2'b0, len_reg});
                        q_reg <= {q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg <= dr_sh[32:0];
                        q_reg <= {q_reg[30:0], 1'b0};
                    end
                    num_reg <= {num_reg[60:0], 1'b0};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        res_reg[comp_reg] <= neg_reg[comp_reg]
                            ? 32'(-{q_reg[30:0], dr_sh >= {2'b0, len_reg}})
                            : {q_reg[30:0], dr_sh >= {2'b0, len_reg}};
                        if (comp_reg == 2'd2)
                            state_reg <= N_IDLE;
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                            cnt_reg <= 6'd62;
                            dr_reg <= '0;
                            q_reg <= '0;
                            num_reg <= {mag_reg[comp_reg + 2'd1][29:0], 30'd0}
                                     + {30'd0, len_reg >> 1};
                        end
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != N_IDLE) || start;
    assign out_x = res_reg[0];
    assign out_y = res_reg[1];
    assign out_z = res_reg[2];

endmodule
`default_nettype wire

/* src/sbm_datapath.sv */
`default_nettype none
module sbm_datapath
    import sbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire sbm_cmd_t cmd,
    input  wire logic first_block,
    input  wire logic signed [31:0] from_x,
    input  wire logic signed [31:0] from_y,
    input  wire logic signed [31:0] from_z,
    input  wire logic signed [31:0] to_x,
    input  wire logic signed [31:0] to_y,
    input  wire logic signed [31:0] to_z,
    input  wire logic [30:0] from_radius,
    input  wire logic [30:0] to_radius,
    input  wire logic [4:0] step,
    output sbm_stat_t stat,
    output sbm_rec_t rec
);

    logic signed [31:0] from_reg [3];
    logic signed [31:0] to_reg [3];
    logic [30:0] rf_reg, rt_reg;
    logic [31:0] base_reg, next_vertex_reg;
    logic signed [31:0] w_reg [3];
    logic signed [31:0] st_reg [3];
    logic signed [31:0] up_reg [3];
    logic signed [63:0] prod_reg [6];
    logic signed [63:0] off_reg [3];
    logic signed [31:0] vert_reg [3];
    logic norm_start;
    logic signed [33:0] nv [3];
    logic norm_busy;
    logic signed [31:0] nout [3];
    logic rev;
    logic [1:0] axis;
    logic [31:0] aw [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] org [3];
    logic [30:0] rad;
    logic dsub;
    logic [8:0] tofs;
    logic [3:0] tri_n;

    // axis pick on w = -n, ties to later axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            aw[i] = w_reg[i][31] ? 32'(-w_reg[i]) : w_reg[i];
        axis = 2'd0;
        rev = w_reg[0][31];
        if (aw[1] >= aw[0])
        begin
            axis = 2'd1;
            rev = w_reg[1][31];
        end
        if (aw[2] >= aw[axis])
        begin
            axis = 2'd2;
            rev = w_reg[2][31];
        end
    end

    always_comb
    begin
        norm_start = 1'b0;
        nv[0] = '0;
        nv[1] = '0;
        nv[2] = '0;
        if (cmd.op == OP_DIFF)
        begin
            norm_start = 1'b1;
            for (int i = 0; i < 3; i++)
                nv[i] = 34'(to_reg[i]) - 34'(from_reg[i]);
        end
        else if (cmd.op == OP_NORM_START)
        begin
            norm_start = 1'b1;
            case (axis)
                2'd2:
                begin
                    nv[0] = '0;
                    nv[1] = 34'(w_reg[2]);
                    nv[2] = -34'(w_reg[1]);
                end
                2'd0:
                begin
                    nv[0] = -34'(w_reg[2]);
                    nv[1] = '0;
                    nv[2] = 34'(w_reg[0]);
                end
                default:
                begin
                    nv[0] = 34'(w_reg[1]);
                    nv[1] = -34'(w_reg[0]);
                    nv[2] = '0;
                end
            endcase
        end
    end

    sbm_norm u_norm (
        .clk(clk), .rst_n(rst_n), .start(norm_start),
        .vin_x(nv[0]), .vin_y(nv[1]), .vin_z(nv[2]),
        .busy(norm_busy),
        .out_x(nout[0]), .out_y(nout[1]), .out_z(nout[2])
    );

    // vertex v: face = v[2], corner = v[1:0]: +st, -up, -st, +up
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dir[i] = cmd.vsel[0] ? up_reg[i] : st_reg[i];
            org[i] = cmd.vsel[2] ? to_reg[i] : from_reg[i];
        end
        rad = cmd.vsel[2] ? rt_reg : rf_reg;
        dsub = cmd.vsel[1:0] == 2'd1 || cmd.vsel[1:0] == 2'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            next_vertex_reg <= '0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            base_reg <= first_block ? 32'd0 : next_vertex_reg;
            next_vertex_reg <= (first_block ? 32'd0 : next_vertex_reg) + VERT_STRIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                from_reg[0] <= from_x;
                from_reg[1] <= from_y;
                from_reg[2] <= from_z;
                to_reg[0] <= to_x;
                to_reg[1] <= to_y;
                to_reg[2] <= to_z;
                rf_reg <= from_radius;
                rt_reg <= to_radius;
            end
            OP_AXIS:
                for (int i = 0; i < 3; i++)
                    w_reg[i] <= 32'(-nout[i]);
            OP_UP_MUL:
            begin
                for (int i = 0; i < 3; i++)
                    st_reg[i] <= rev ? 32'(-nout[i]) : nout[i];
                prod_reg[0] <= (rev ? -64'(nout[1]) : 64'(nout[1])) * 64'(w_reg[2]);
                prod_reg[1] <= (rev ? -64'(nout[2]) : 64'(nout[2])) * 64'(w_reg[1]);
                prod_reg[2] <= (rev ? -64'(nout[2]) : 64'(nout[2])) * 64'(w_reg[0]);
                prod_reg[3] <= (rev ? -64'(nout[0]) : 64'(nout[0])) * 64'(w_reg[2]);
                prod_reg[4] <= (rev ? -64'(nout[0]) : 64'(nout[0])) * 64'(w_reg[1]);
                prod_reg[5] <= (rev ? -64'(nout[1]) : 64'(nout[1])) * 64'(w_reg[0]);
            end
            OP_UP_SUM:
            begin
                up_reg[0] <= 32'(rnd30(prod_reg[0] - prod_reg[1]));
                up_reg[1] <= 32'(rnd30(prod_reg[2] - prod_reg[3]));
                up_reg[2] <= 32'(rnd30(prod_reg[4] - prod_reg[5]));
            end
            OP_VERT_MUL:
                for (int i = 0; i < 3; i++)
                    off_reg[i] <= rnd30(64'(dir[i]) * $signed({33'd0, rad}));
            OP_VERT_ADD:
                for (int i = 0; i < 3; i++)
                    vert_reg[i] <= sat32(dsub ? 64'(org[i]) - off_reg[i]
                                              : 64'(org[i]) + off_reg[i]);
            default: ;
        endcase
    end

    assign stat.norm_busy = norm_busy;

    assign tri_n = 4'(step - 5'd8);
    assign tofs = tri_offsets(tri_n);

    always_comb
    begin
        rec = '0;
        if (step < 5'(NUM_VERTS))
        begin
            rec.kind = KIND_VERTEX;
            rec.vertex_index = base_reg + 32'(step);
            rec.vertex_x = vert_reg[0];
            rec.vertex_y = vert_reg[1];
            rec.vertex_z = vert_reg[2];
        end
        else
        begin
            rec.kind = KIND_TRI;
            rec.tri_a = base_reg + 32'(tofs[8:6]);
            rec.tri_b = base_reg + 32'(tofs[5:3]);
            rec.tri_c = base_reg + 32'(tofs[2:0]);
            rec.last = step == 5'(NUM_RESULTS - 1);
        end
    end

endmodule
`default_nettype wire

/* src/sbm_ctrl.sv */
`default_nettype none
module sbm_ctrl
    import sbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic out_ready,
    input  wire sbm_stat_t stat,
    output sbm_cmd_t cmd,
    output logic in_ready,
    output logic out_valid,
    output logic [4:0] step,
    output logic out_load
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_NWAIT1, S_AXIS, S_NST, S_NWAIT2, S_UPM, S_UPS,
        S_VMUL, S_VADD, S_EMIT
    } state_t;

    state_t state_reg;
    logic [4:0] step_reg;
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:   if (in_fire) state_reg <= S_DIFF;
                S_DIFF:   state_reg <= S_NWAIT1;
                S_NWAIT1: if (!stat.norm_busy) state_reg <= S_AXIS;
                S_AXIS:   state_reg <= S_NST;
                S_NST:    state_reg <= S_NWAIT2;
                S_NWAIT2: if (!stat.norm_busy) state_reg <= S_UPM;
                S_UPM:    state_reg <= S_UPS;
                S_UPS:
                begin
                    step_reg <= '0;
                    state_reg <= S_VMUL;
                end
                S_VMUL:   state_reg <= S_VADD;
                S_VADD:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        step_reg <= step_reg + 5'd1;
                        if (step_reg == 5'(NUM_RESULTS - 1))
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else if (step_reg < 5'(NUM_VERTS - 1))
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg <= S_VMUL;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.vsel = step_reg[2:0];
        case (state_reg)
            S_IDLE:  cmd.op = in_fire ? OP_LOAD : OP_NONE;
            S_DIFF:  cmd.op = OP_DIFF;
            S_AXIS:  cmd.op = OP_AXIS;
            S_NST:   cmd.op = OP_NORM_START;
            S_NWAIT2: cmd.op = OP_NONE;
            S_UPM:   cmd.op = OP_UP_MUL;
            S_UPS:   cmd.op = OP_UP_SUM;
            S_VMUL:  cmd.op = OP_VERT_MUL;
            S_VADD:  cmd.op = OP_VERT_ADD;
            default: cmd.op = OP_NONE;
        endcase
    end

    // start of the second normalize follows the axis latch
    assign in_ready = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign step = step_reg;
    assign out_load = state_reg == S_AXIS;

endmodule
`default_nettype wire

/* src/sbm_checker.sv */
`default_nettype none
`include "segment_box_mesh_builder_unit_assert.svh"
module sbm_checker
    import sbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_ready,
    input  wire logic out_valid,
    input  wire logic out_ready,
    input  wire logic kind,
    input  wire logic last
);

    `SBM_ASSERT(a_no_accept_busy, !(in_ready && out_valid), "input taken while emitting")
    `SBM_ASSERT(a_last_is_tri, !(out_valid && last) || kind == KIND_TRI, "last on vertex")
    `SBM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output dropped")
    `SBM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

endmodule

bind segment_box_mesh_builder_unit sbm_checker u_sbm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .last(last)
);
`default_nettype wire

/* test/tb_segment_box_mesh_builder_unit.sv */
`timescale 1ns / 1ps
module tb_segment_box_mesh_builder_unit;
    import sbm_pkg::*;

    typedef longint vec3_t [3];

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned DRAIN_CYCLES = 600;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic first_block;
    logic signed [31:0] from_x, from_y, from_z;
    logic signed [31:0] to_x, to_y, to_z;
    logic [30:0] from_radius, to_radius;
    logic out_valid;
    logic out_ready;
    logic kind;
    logic [31:0] vertex_index;
    logic signed [31:0] vertex_x, vertex_y, vertex_z;
    logic [31:0] tri_a, tri_b, tri_c;
    logic last;

    sbm_rec_t box_q [$];
    logic [31:0] vertex_count;
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned segments_sent;
    int unsigned records_seen;
    bit calm;

    segment_box_mesh_builder_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .first_block(first_block),
        .from_x(from_x),
        .from_y(from_y),
        .from_z(from_z),
        .to_x(to_x),
        .to_y(to_y),
        .to_z(to_z),
        .from_radius(from_radius),
        .to_radius(to_radius),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .vertex_index(vertex_index),
        .vertex_x(vertex_x),
        .vertex_y(vertex_y),
        .vertex_z(vertex_z),
        .tri_a(tri_a),
        .tri_b(tri_b),
        .tri_c(tri_c),
        .last(last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'h1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // halves away from zero
    function automatic longint round30(input longint v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        r = (mag + 64'h2000_0000) >> 30;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic void unit_vec(input vec3_t v, output vec3_t o);
        logic [63:0] mag [3];
        logic [63:0] m, sum, len, q;
        bit neg [3];
        m = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
        begin
            o[0] = 0;
            o[1] = 0;
            o[2] = 0;
            return;
        end
        while (m >= (64'h1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
            m = m >> 1;
        end
        while (m < (64'h1 << 29))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] << 1;
            m = m << 1;
        end
        for (int i = 0; i < 3; i++)
            sum = sum + mag[i] * mag[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic logic [31:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // expected 8 vertices and 12 triangles of one box
    task automatic predict_box(input logic fb, input logic signed [31:0] f [3],
                               input logic signed [31:0] t [3],
                               input logic [30:0] rf, input logic [30:0] rt);
        vec3_t d, n, w, c, st, up, dir, org;
        longint off, rad;
        longint best, a;
        int axis;
        bit rev;
        logic [31:0] base;
        logic [31:0] quads [6][4];
        sbm_rec_t rec;
        int k;
        if (fb)
            vertex_count = 0;
        for (int i = 0; i < 3; i++)
            d[i] = longint'(t[i]) - longint'(f[i]);
        unit_vec(d, n);
        for (int i = 0; i < 3; i++)
            w[i] = -n[i];
        axis = 0;
        best = (w[0] < 0) ? -w[0] : w[0];
        rev = w[0] < 0;
        for (int i = 1; i < 3; i++)
        begin
            a = (w[i] < 0) ? -w[i] : w[i];
            if (a >= best)
            begin
                best = a;
                axis = i;
                rev = w[i] < 0;
            end
        end
        case ((axis + 1) % 3)
            0: begin c[0] = 0;     c[1] = w[2];  c[2] = -w[1]; end
            1: begin c[0] = -w[2]; c[1] = 0;     c[2] = w[0];  end
            default: begin c[0] = w[1]; c[1] = -w[0]; c[2] = 0; end
        endcase
        unit_vec(c, st);
        if (rev)
            for (int i = 0; i < 3; i++)
                st[i] = -st[i];
        up[0] = round30(st[1] * w[2] - st[2] * w[1]);
        up[1] = round30(st[2] * w[0] - st[0] * w[2]);
        up[2] = round30(st[0] * w[1] - st[1] * w[0]);

        base = vertex_count;
        for (int face = 0; face < 2; face++)
        begin
            rad = (face == 0) ? longint'(rf) : longint'(rt);
            for (int i = 0; i < 3; i++)
                org[i] = (face == 0) ? longint'(f[i]) : longint'(t[i]);
            // corners: +start, -up, -start, +up
            for (int corner = 0; corner < 4; corner++)
            begin
                for (int i = 0; i < 3; i++)
                    dir[i] = (corner % 2 == 0) ? st[i] : up[i];
                rec = '0;
                rec.kind = KIND_VERTEX;
                rec.vertex_index = base + 32'(face * 4 + corner);
                for (int i = 0; i < 3; i++)
                begin
                    off = round30(dir[i] * rad);
                    if (corner == 0 || corner == 3)
                        off = org[i] + off;
                    else
                        off = org[i] - off;
                    case (i)
                        0: rec.vertex_x = clamp_q16(off);
                        1: rec.vertex_y = clamp_q16(off);
                        default: rec.vertex_z = clamp_q16(off);
                    endcase
                end
                box_q = {box_q, rec};
            end
        end

        for (int i = 0; i < 4; i++)
        begin
            quads[0][i] = base + 32'(i);
            quads[5][i] = base + 32'(7 - i);
            quads[1 + i][0] = base + 32'((i + 1) % 4);
            quads[1 + i][1] = base + 32'(i);
            quads[1 + i][2] = base + 32'(4 + i);
            quads[1 + i][3] = base + 32'(4 + (i + 1) % 4);
        end
        k = 0;
        for (int q = 0; q < 6; q++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                rec = '0;
                rec.kind = KIND_TRI;
                rec.tri_a = quads[q][h == 0 ? 0 : 2];
                rec.tri_b = quads[q][h == 0 ? 1 : 3];
                rec.tri_c = quads[q][h == 0 ? 2 : 0];
                rec.last = (k == 11);
                box_q = {box_q, rec};
                k++;
            end
        end
        vertex_count = base + VERT_STRIDE;
    endtask

    // called at a rising edge; valid stays up after acceptance unless idling follows
    task automatic send_segment(input logic fb, input logic signed [31:0] fx,
                                input logic signed [31:0] fy, input logic signed [31:0] fz,
                                input logic signed [31:0] tx, input logic signed [31:0] ty,
                                input logic signed [31:0] tz, input logic [30:0] rf,
                                input logic [30:0] rt);
        logic signed [31:0] f [3];
        logic signed [31:0] t [3];
        f[0] = fx; f[1] = fy; f[2] = fz;
        t[0] = tx; t[1] = ty; t[2] = tz;
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        first_block <= fb;
        from_x <= fx;
        from_y <= fy;
        from_z <= fz;
        to_x <= tx;
        to_y <= ty;
        to_z <= tz;
        from_radius <= rf;
        to_radius <= rt;
        do
            @(posedge clk);
        while (!in_ready);
        predict_box(fb, f, t, rf, rt);
        segments_sent++;
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        sbm_rec_t e;
        if (rst_n && out_valid && out_ready)
        begin
            records_seen++;
            if (box_q.size() == 0)
            begin
                $error("unexpected record kind=%b index=%h", kind, vertex_index);
                error_count++;
            end
            else
            begin
                e = box_q.pop_front();
                check_field("kind", 32'(e.kind), 32'(kind));
                check_field("vertex_index", e.vertex_index, vertex_index);
                check_field("vertex_x", e.vertex_x, vertex_x);
                check_field("vertex_y", e.vertex_y, vertex_y);
                check_field("vertex_z", e.vertex_z, vertex_z);
                check_field("tri_a", e.tri_a, tri_a);
                check_field("tri_b", e.tri_b, tri_b);
                check_field("tri_c", e.tri_c, tri_c);
                check_field("last", 32'(e.last), 32'(last));
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 37);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d records outstanding", box_q.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord(input bit wide);
        if (wide)
            return $urandom;
        return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
    endfunction

    task automatic test_axes;
        logic signed [31:0] one;
        one = 32'sh0001_0000;
        send_segment(1'b1, 0, 0, 0, one, 0, 0, 31'h0001_0000, 31'h0002_0000);
        send_segment(1'b0, 0, 0, 0, -one, 0, 0, 31'h0001_0000, 31'h0001_0000);
        send_segment(1'b0, 0, 0, 0, 0, one, 0, 31'h0000_8000, 31'h0001_0000);
        send_segment(1'b0, 0, 0, 0, 0, -one, 0, 31'h0001_0000, 31'h0000_4000);
        send_segment(1'b0, 0, 0, 0, 0, 0, one, 31'h0003_0000, 31'h0001_0000);
        send_segment(1'b0, one, one, one, one, one, 0, 31'h0001_0000, 31'h0001_0000);
    endtask

    task automatic test_ties;
        // equal magnitudes pick the later axis
        send_segment(1'b0, 0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                     31'h0001_0000, 31'h0001_0000);
        send_segment(1'b0, 0, 0, 0, -32'sh10000, 32'sh10000, -32'sh10000,
                     31'h0002_0000, 31'h0001_0000);
        send_segment(1'b0, 0, 0, 0, 32'sh10000, -32'sh10000, 0,
                     31'h0001_0000, 31'h0003_0000);
        send_segment(1'b0, 5, -7, 3, 4, -6, 2, 31'h0000_0001, 31'h7fff_ffff);
    endtask

    task automatic test_degenerate;
        // zero-length segment: all corners sit on the endpoints
        send_segment(1'b1, 32'sh0003_0000, -32'sh0002_0000, 32'sh0001_0000,
                     32'sh0003_0000, -32'sh0002_0000, 32'sh0001_0000,
                     31'h0001_0000, 31'h0005_0000);
        send_segment(1'b0, 32'sh7fff_ffff, 32'sh8000_0000, 0,
                     32'sh7fff_ffff, 32'sh8000_0000, 0, 31'h7fff_ffff, 31'h7fff_ffff);
        send_segment(1'b0, 0, 0, 0, 1, 0, 0, 31'h0000_0000, 31'h0000_0000);
        send_segment(1'b0, 0, 0, 0, 0, 0, -1, 31'h0001_0000, 31'h0000_0000);
    endtask

    task automatic test_extremes;
        logic signed [31:0] lo, hi;
        lo = 32'sh8000_0000;
        hi = 32'sh7fff_ffff;
        send_segment(1'b0, lo, lo, lo, hi, hi, hi, 31'h7fff_ffff, 31'h7fff_ffff);
        send_segment(1'b0, hi, hi, hi, lo, lo, lo, 31'h7fff_ffff, 31'h4000_0000);
        send_segment(1'b0, lo, hi, lo, hi, lo, hi, 31'h7fff_ffff, 31'h0000_0001);
        send_segment(1'b1, hi, 0, lo, lo, 0, hi, 31'h5555_5555, 31'h2aaa_aaaa);
        send_segment(1'b0, hi, hi, 0, hi, hi - 1, 0, 31'h7fff_ffff, 31'h7fff_ffff);
        send_segment(1'b0, lo, lo, lo, lo + 1, lo, lo, 31'h7fff_ffff, 31'h7fff_ffff);
    endtask

    task automatic test_random_mesh;
        bit wide;
        logic [30:0] rf, rt;
        logic signed [31:0] px, py, pz;
        for (int i = 0; i < 330; i++)
        begin
            calm = (i >= 120 && i < 170);
            wide = $urandom_range(0, 99) < 40;
            rf = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h000f_ffff));
            rt = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h000f_ffff));
            if ($urandom_range(0, 19) == 0)
            begin
                // degenerate segment now and then
                px = rand_coord(wide);
                py = rand_coord(wide);
                pz = rand_coord(wide);
                send_segment($urandom_range(0, 7) == 0, px, py, pz, px, py, pz, rf, rt);
            end
            else
                send_segment($urandom_range(0, 7) == 0, rand_coord(wide), rand_coord(wide),
                             rand_coord(wide), rand_coord(wide), rand_coord(wide),
                             rand_coord(wide), rf, rt);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        int unsigned wait_cycles;
        rst_n = 1'b0;
        in_valid <= 1'b0;
        first_block <= 1'b0;
        from_x <= 0;
        from_y <= 0;
        from_z <= 0;
        to_x <= 0;
        to_y <= 0;
        to_z <= 0;
        from_radius <= 0;
        to_radius <= 0;
        vertex_count = 0;
        cycle_count = 0;
        error_count = 0;
        segments_sent = 0;
        records_seen = 0;
        calm = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_axes();
        test_ties();
        test_degenerate();
        test_extremes();
        test_random_mesh();

        in_valid <= 1'b0;
        while (box_q.size() != 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < DRAIN_CYCLES)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        $display("segments sent: %0d, records checked: %0d", segments_sent, records_seen);
        $display("covered axis directions, ties, zero length, saturation, mesh restarts");
        if (error_count == 0 && box_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
